// ----- design/avsfd_pkg.sv -----
// Package for the A/V sync frame drop/duplicate block.
// Holds widths, limits, register indexes and the controller state type.
// No dependencies.
`default_nettype none

package avsfd_pkg;

    localparam int TC_W     = 32;   // timecodes
    localparam int AB_W     = 20;   // audio bytes per frame
    localparam int RATE_W   = 20;   // audio bytes per second
    localparam int PER_W    = 18;   // frame period, Q.8 ms
    localparam int TOT_W    = 48;   // running audio byte total
    localparam int FC_W     = 32;   // frame count
    localparam int BLK_W    = 14;   // blank frame count
    localparam int DVD_W    = TOT_W + 10;          // total * 1000
    localparam int ACC_W    = FC_W + PER_W + 1;    // signed product
    localparam int VID_W    = ACC_W - 8;           // product / 256
    localparam int TA_W     = TC_W + 2;            // tc - audio end
    localparam int DELTA_W  = DVD_W + 3;           // drift difference
    localparam int CNT_W    = 6;
    localparam int DIV_STEPS = DVD_W;
    localparam int MUL_STEPS = FC_W;

    localparam logic [RATE_W-1:0] RATE_RESET   = RATE_W'(192000);
    localparam logic [PER_W-1:0]  PERIOD_RESET = PER_W'(8533);
    localparam logic [PER_W-1:0]  PERIOD_MIN   = PER_W'(256);

    localparam int SMALL_LIMIT = 500;
    localparam int LARGE_LIMIT = 10000;
    localparam int ROUND_HALF  = 128;
    localparam int ROUND_NEG   = 383;   // half plus 255 for truncation toward zero

    localparam logic [2:0]        RECOVER_WAIT = 3'd6;
    localparam logic signed [3:0] PEND_LARGE   = 4'sd5;

    typedef logic [0:0] t_cfg_idx;
    localparam t_cfg_idx CFG_AUDIO_RATE   = 1'b0;
    localparam t_cfg_idx CFG_FRAME_PERIOD = 1'b1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_LOAD,
        S_RUN,
        S_VID,
        S_D1,
        S_D2,
        S_DEC,
        S_BLANK,
        S_FIN
    } t_state;

endpackage

`default_nettype wire

// ----- design/av_sync_frame_drop_dup.sv -----
// Top level of the A/V sync frame drop/duplicate block; uses avsfd_pkg.
// Per request: load, the 58-step bit-serial divide for the audio buffer time (with the
// frame count multiply beside it), video time, drift, decision, blank frames when a
// recovery inserts them, then the result; a result stall holds the final state.
// A new request is accepted only in idle, after the previous result is loaded.
// Reset (i_rst_n, synchronous, active low) clears sync state, out valid; presets config.
`default_nettype none

module av_sync_frame_drop_dup (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    // request channel
    input  wire logic                          i_in_valid,
    output logic                               o_in_stall,
    input  wire logic [avsfd_pkg::TC_W-1:0]    i_frame_timecode_ms,
    input  wire logic [avsfd_pkg::AB_W-1:0]    i_audio_bytes,
    input  wire logic [avsfd_pkg::TC_W-1:0]    i_audio_end_ms,
    // result channel
    output logic                               o_out_valid,
    input  wire logic                          i_out_stall,
    output logic [avsfd_pkg::TC_W-1:0]         o_fixed_timecode_ms,
    output logic [avsfd_pkg::BLK_W-1:0]        o_blank_frames,
    output logic                               o_audio_written,
    output logic [1:0]                         o_video_copies,
    // configuration write
    input  wire logic                          i_cfg_valid,
    output logic                               o_cfg_ready,
    input  wire avsfd_pkg::t_cfg_idx           i_cfg_index,
    input  wire logic [avsfd_pkg::RATE_W-1:0]  i_cfg_data
);

    localparam int DW = avsfd_pkg::DELTA_W;
    localparam int AW = avsfd_pkg::ACC_W;

    avsfd_pkg::t_state r_state, n_state;

    logic [avsfd_pkg::RATE_W-1:0] r_rate;
    logic [avsfd_pkg::PER_W-1:0]  r_period;

    logic [avsfd_pkg::TC_W-1:0]   r_last;
    logic [avsfd_pkg::TOT_W-1:0]  r_total;
    logic [avsfd_pkg::FC_W-1:0]   r_fc;
    logic signed [3:0]            r_pending;
    logic [2:0]                   r_recover;

    logic [avsfd_pkg::TC_W-1:0]   r_tc;
    logic [avsfd_pkg::TC_W-1:0]   r_aend;
    logic                         r_aw;
    logic signed [avsfd_pkg::TA_W-1:0] r_ta;
    logic [avsfd_pkg::DVD_W-1:0]  r_dvd;
    logic [avsfd_pkg::RATE_W-1:0] r_rem;
    logic [avsfd_pkg::FC_W-1:0]   r_fc_sh;
    logic signed [AW-1:0]         r_acc;
    logic [avsfd_pkg::CNT_W-1:0]  r_cnt;
    logic signed [avsfd_pkg::VID_W-1:0] r_vid;
    logic signed [DW-1:0]         r_delta;
    logic [avsfd_pkg::BLK_W-1:0]  r_blank_rem;
    logic [avsfd_pkg::BLK_W-1:0]  r_blanks;

    logic                         r_out_valid;
    logic [avsfd_pkg::TC_W-1:0]   r_out_tc;
    logic [avsfd_pkg::BLK_W-1:0]  r_out_blanks;
    logic                         r_out_aw;
    logic [1:0]                   r_out_copies;

    // effective configuration
    logic [avsfd_pkg::PER_W-1:0]  per_eff;
    logic [avsfd_pkg::RATE_W-1:0] rate_eff;
    logic [9:0]                   fint;

    assign per_eff  = (r_period < avsfd_pkg::PERIOD_MIN) ? avsfd_pkg::PERIOD_MIN : r_period;
    assign rate_eff = (r_rate == '0) ? avsfd_pkg::RATE_W'(1) : r_rate;
    assign fint     = per_eff[avsfd_pkg::PER_W-1:8];

    logic in_acc, out_free;
    assign in_acc   = i_in_valid && !o_in_stall;
    assign out_free = !r_out_valid || !i_out_stall;

    // monotonic timecode and saturating audio total
    logic [avsfd_pkg::TC_W:0]   tc_sum;
    logic [avsfd_pkg::TC_W-1:0] tc_fix;
    logic [avsfd_pkg::TOT_W:0]  tot_sum;

    assign tc_sum  = {1'b0, r_last} + {23'b0, fint};
    assign tc_fix  = (i_frame_timecode_ms >= r_last) ? i_frame_timecode_ms :
                     (tc_sum[avsfd_pkg::TC_W] ? '1 : tc_sum[avsfd_pkg::TC_W-1:0]);
    assign tot_sum = {1'b0, r_total} + {29'b0, i_audio_bytes};

    // restoring divide step, one quotient bit per cycle
    logic [avsfd_pkg::RATE_W:0] rem_sh, rem_nx;
    logic                       div_ge;

    assign rem_sh = {r_rem, r_dvd[avsfd_pkg::DVD_W-1]};
    assign div_ge = rem_sh >= {1'b0, rate_eff};
    assign rem_nx = div_ge ? (rem_sh - {1'b0, rate_eff}) : rem_sh;

    // MSB-first signed shift-add multiply, sign bit weighs negative
    logic signed [AW-1:0] mul_add, acc_nx;
    assign mul_add = r_fc_sh[avsfd_pkg::FC_W-1] ? $signed({33'b0, per_eff}) : '0;
    assign acc_nx  = (r_cnt == '0) ? ((r_acc <<< 1) - mul_add) : ((r_acc <<< 1) + mul_add);

    // rounding of count * period / 256, truncated toward zero
    logic signed [AW-1:0] vid_y;
    assign vid_y = r_acc + ((r_acc < -AW'(avsfd_pkg::ROUND_HALF)) ?
                            AW'(avsfd_pkg::ROUND_NEG) : AW'(avsfd_pkg::ROUND_HALF));

    // drift decision
    logic                 d_neg, d_small, d_large;
    logic signed [DW-1:0] d_mag;
    logic signed [3:0]    dec_pend;
    logic [2:0]           dec_rec;
    logic                 dec_blank;

    assign d_neg   = r_delta[DW-1];
    assign d_mag   = d_neg ? -r_delta : r_delta;
    assign d_small = (d_mag < DW'(avsfd_pkg::SMALL_LIMIT)) &&
                     ({1'b0, d_mag[8:0], 8'b0} >= per_eff);
    assign d_large = !d_neg && (r_delta >= DW'(avsfd_pkg::SMALL_LIMIT)) &&
                     (r_delta < DW'(avsfd_pkg::LARGE_LIMIT));

    always_comb begin
        dec_pend  = 4'sd0;
        dec_rec   = 3'd0;
        dec_blank = 1'b0;
        if (d_small) begin
            dec_pend = d_neg ? -4'sd1 : 4'sd1;
        end else if (d_large) begin
            if (r_recover == 3'd0) begin
                dec_pend = avsfd_pkg::PEND_LARGE;
                dec_rec  = avsfd_pkg::RECOVER_WAIT;
            end else if (r_recover == 3'd1) begin
                dec_blank = 1'b1;
            end else begin
                dec_pend = r_pending;
                dec_rec  = r_recover - 3'd1;
            end
        end
    end

    // blank insertion: one frame period off the remaining lead per cycle
    logic blank_more;
    assign blank_more = {r_blank_rem, 8'b0} > {4'b0, per_eff};

    // copies and frame count at the end of the request
    logic [1:0]        fin_copies;
    logic signed [3:0] fin_pend;
    always_comb begin
        if (r_pending < 0) begin
            fin_copies = 2'd0;
            fin_pend   = r_pending + 4'sd1;
        end else if (r_pending > 0) begin
            fin_copies = 2'd2;
            fin_pend   = r_pending - 4'sd1;
        end else begin
            fin_copies = 2'd1;
            fin_pend   = r_pending;
        end
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= avsfd_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_in_stall = (r_state != avsfd_pkg::S_IDLE);
        case (r_state)
            avsfd_pkg::S_IDLE:  if (i_in_valid) n_state = avsfd_pkg::S_LOAD;
            avsfd_pkg::S_LOAD:  n_state = avsfd_pkg::S_RUN;
            avsfd_pkg::S_RUN: begin
                if (r_cnt == avsfd_pkg::CNT_W'(avsfd_pkg::DIV_STEPS - 1))
                    n_state = avsfd_pkg::S_VID;
            end
            avsfd_pkg::S_VID:   n_state = avsfd_pkg::S_D1;
            avsfd_pkg::S_D1:    n_state = avsfd_pkg::S_D2;
            avsfd_pkg::S_D2:    n_state = avsfd_pkg::S_DEC;
            avsfd_pkg::S_DEC:   n_state = dec_blank ? avsfd_pkg::S_BLANK : avsfd_pkg::S_FIN;
            avsfd_pkg::S_BLANK: if (!blank_more) n_state = avsfd_pkg::S_FIN;
            avsfd_pkg::S_FIN:   if (out_free) n_state = avsfd_pkg::S_IDLE;
            default:            n_state = avsfd_pkg::S_IDLE;
        endcase
    end

    // configuration and sync state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rate    <= avsfd_pkg::RATE_RESET;
            r_period  <= avsfd_pkg::PERIOD_RESET;
            r_last    <= '0;
            r_total   <= '0;
            r_fc      <= '0;
            r_pending <= 4'sd0;
            r_recover <= 3'd0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    avsfd_pkg::CFG_AUDIO_RATE:   r_rate   <= i_cfg_data;
                    avsfd_pkg::CFG_FRAME_PERIOD: r_period <= i_cfg_data[avsfd_pkg::PER_W-1:0];
                    default: ;
                endcase
            end
            if (in_acc) begin
                r_last  <= tc_fix;
                r_total <= tot_sum[avsfd_pkg::TOT_W] ? '1 : tot_sum[avsfd_pkg::TOT_W-1:0];
            end
            if (r_state == avsfd_pkg::S_DEC) begin
                r_pending <= dec_pend;
                r_recover <= dec_rec;
            end
            if (r_state == avsfd_pkg::S_FIN && out_free) begin
                r_pending <= fin_pend;
                r_fc      <= r_fc + {18'b0, r_blanks} + {30'b0, fin_copies};
            end
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        case (r_state)
            avsfd_pkg::S_IDLE: begin
                r_tc   <= tc_fix;
                r_aend <= i_audio_end_ms;
                r_aw   <= (i_audio_bytes != '0);
            end
            avsfd_pkg::S_LOAD: begin
                // total * 1000 = total * 1024 - total * 16 - total * 8
                r_dvd   <= {r_total, 10'b0} - {6'b0, r_total, 4'b0} - {7'b0, r_total, 3'b0};
                r_rem   <= '0;
                r_fc_sh <= r_fc;
                r_acc   <= '0;
                r_cnt   <= '0;
                r_ta    <= $signed({2'b0, r_tc}) - $signed({2'b0, r_aend});
            end
            avsfd_pkg::S_RUN: begin
                r_rem <= rem_nx[avsfd_pkg::RATE_W-1:0];
                r_dvd <= {r_dvd[avsfd_pkg::DVD_W-2:0], div_ge};
                if (r_cnt < avsfd_pkg::CNT_W'(avsfd_pkg::MUL_STEPS)) begin
                    r_acc   <= acc_nx;
                    r_fc_sh <= {r_fc_sh[avsfd_pkg::FC_W-2:0], 1'b0};
                end
                r_cnt <= r_cnt + 1'b1;
            end
            avsfd_pkg::S_VID: r_vid <= vid_y[AW-1:8];
            // delta = audio buffer time - video time + (tc - audio end)
            avsfd_pkg::S_D1: begin
                r_delta <= $signed({3'b0, r_dvd}) -
                           $signed({{(DW - avsfd_pkg::VID_W){r_vid[avsfd_pkg::VID_W-1]}}, r_vid});
            end
            avsfd_pkg::S_D2: begin
                r_delta <= r_delta +
                           $signed({{(DW - avsfd_pkg::TA_W){r_ta[avsfd_pkg::TA_W-1]}}, r_ta});
            end
            avsfd_pkg::S_DEC: begin
                r_blank_rem <= r_delta[avsfd_pkg::BLK_W-1:0];
                r_blanks    <= '0;
            end
            avsfd_pkg::S_BLANK: begin
                if (blank_more) begin
                    r_blank_rem <= r_blank_rem - {4'b0, fint};
                    r_blanks    <= r_blanks + 1'b1;
                end
            end
            default: ;
        endcase
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == avsfd_pkg::S_FIN && out_free) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == avsfd_pkg::S_FIN && out_free) begin
            r_out_tc     <= r_tc;
            r_out_blanks <= r_blanks;
            r_out_aw     <= r_aw;
            r_out_copies <= fin_copies;
        end
    end

    assign o_out_valid         = r_out_valid;
    assign o_fixed_timecode_ms = r_out_tc;
    assign o_blank_frames      = r_out_blanks;
    assign o_audio_written     = r_out_aw;
    assign o_video_copies      = r_out_copies;
    assign o_cfg_ready         = 1'b1;

    // checks
    a_recover_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_recover <= avsfd_pkg::RECOVER_WAIT)
        else $error("recovery wait out of range");

    a_pending_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pending >= -4'sd1) && (r_pending <= avsfd_pkg::PEND_LARGE))
        else $error("pending adjust out of range");

    a_copies_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_video_copies != 2'd3))
        else $error("bad copies code");

    a_blank_normal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_blank_frames != '0)) |-> (o_video_copies == 2'd1))
        else $error("blank insertion with drop or duplicate");

    a_load_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_out_stall) |=> ($stable(r_out_tc) && $stable(r_out_copies)))
        else $error("waiting result overwritten");

endmodule

`default_nettype wire
